@@ rtl/core/dfs_finish_order_and_components_core_assert.svh @@
// Assertion macros for the DFS finish-order and component core.
// Used by the top level; depends on clk_i and rst_ni in the including scope.
`ifndef DFS_FINISH_ORDER_AND_COMPONENTS_CORE_ASSERT_SVH
`define DFS_FINISH_ORDER_AND_COMPONENTS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DFSFC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFSFC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dfsfc_pkg.sv @@
// Shared types and constants for the DFS finish-order and component core.
// No dependencies.
package dfsfc_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ValueW = 11;
  localparam int unsigned CountW = 10;
  localparam int unsigned VcW    = 11;
  localparam logic [VcW-1:0] VcReset = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR_ALL    = 3'd0,
    OP_ADD_EDGE     = 3'd1,
    OP_CLEAR_SEARCH = 3'd2,
    OP_FINISH_PASS  = 3'd3,
    OP_WRITE_ORDER  = 3'd4,
    OP_COMP_PASS    = 3'd5,
    OP_READ_FINISH  = 3'd6,
    OP_READ_SIZE    = 3'd7
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] tail_or_index;
    logic [IdxW-1:0] head_or_vertex;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] component_count;
    logic              error;
  } out_item_t;

endpackage

@@ rtl/core/dfsfc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dfsfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dfs_finish_order_and_components_core.sv @@
// Each item passes through its own states to S_FIN: clears sweep the search state first,
// edge adds link the list in S_LINK, reads fetch in S_READ, and order writes and errors
// go straight to S_FIN. A pass scans roots and walks edges and searched vertices
// through the search states, waiting on the registered memory reads.
// One item at a time; the next item is taken while the last result waits.
// After reset the core sweeps its mark, finish and list memories over all MAX_VERTICES
// entries with in_stall_o high; configuration writes are taken throughout.
`include "dfs_finish_order_and_components_core_assert.svh"

module dfs_finish_order_and_components_core
  import dfsfc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [VcW-1:0]     cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  // Widths: vertex address, vertex count, edge index with its nil code, edge address.
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int EW    = $clog2(MAX_EDGES + 1);
  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SLOTS = MAX_VERTICES / 2 + 1;
  localparam int SAW   = $clog2(SLOTS);
  localparam int SW    = $clog2(SLOTS + 1);
  localparam logic [EW-1:0] NIL      = EW'(MAX_EDGES);
  localparam logic [VW-1:0] LAST_VTX = VW'(MAX_VERTICES - 1);

  // One-hot sequencer states.
  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_SWEEP  = 15'h0002,
    S_LINK   = 15'h0004,
    S_READ   = 15'h0008,
    S_FIN    = 15'h0010,
    S_RNEXT  = 15'h0020,
    S_RORD   = 15'h0040,
    S_RCHK   = 15'h0080,
    S_RSTART = 15'h0100,
    S_STEP   = 15'h0200,
    S_EDGE   = 15'h0400,
    S_MARK   = 15'h0800,
    S_PUSH   = 15'h1000,
    S_POP    = 15'h2000,
    S_RDONE  = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [VcW-1:0] vcount_q, vcount_d;
  logic [EW-1:0]  edge_used_q, edge_used_d;
  logic [NW-1:0]  total_q, total_d;
  logic [SW-1:0]  sizes_q, sizes_d;
  logic [VW-1:0]  cnt_q, cnt_d;
  logic           clr_list_q, clr_list_d;
  logic           pend_q, pend_d;
  logic           out_valid_q, out_valid_d;

  // Working registers of the current item.
  op_e             op_q, op_d;
  logic [VW-1:0]   a_q, a_d;
  logic [EAW-1:0]  e_q, e_d;
  logic [ValueW-1:0] res_value_q, res_value_d;
  logic            res_err_q, res_err_d;
  logic            comp_q, comp_d;
  logic [NW-1:0]   i_q, i_d;
  logic [VW-1:0]   root_q, root_d;
  logic [NW-1:0]   before_q, before_d;
  logic [VW-1:0]   top_v_q, top_v_d;
  logic [EW-1:0]   top_c_q, top_c_d;
  logic [NW-1:0]   depth_q, depth_d;
  logic [VW-1:0]   h_q, h_d;
  out_item_t       out_data_q, out_data_d;

  // Memory ports.
  logic heads_we, next_we, list_we, expl_we, fin_we, ord_we, stk_we, size_we;
  logic [EAW-1:0] heads_waddr, heads_raddr, next_waddr, next_raddr;
  logic [VW-1:0]  heads_wdata, heads_rdata;
  logic [EW-1:0]  next_wdata, next_rdata;
  logic [VW-1:0]  list_waddr, list_raddr;
  logic [2*EW-1:0] list_wdata, list_rdata;
  logic [VW-1:0]  expl_waddr, expl_raddr;
  logic           expl_wdata, expl_rdata;
  logic [VW-1:0]  fin_waddr, fin_raddr, fin_wdata, fin_rdata;
  logic [VW-1:0]  ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [VW-1:0]  stk_waddr, stk_raddr;
  logic [VW+EW-1:0] stk_wdata, stk_rdata;
  logic [SAW-1:0] size_waddr, size_raddr;
  logic [NW-1:0]  size_wdata, size_rdata;

  // Effective vertex count and helpers.
  logic [NW-1:0] n_w;
  logic [31:0]   n32, a32, b32;
  logic          out_free;
  logic [NW-1:0] tot_w, sz_w, adv_w;
  logic [EW-1:0] first_w, last_w;

  assign n_w = (32'(vcount_q) < 32'(MAX_VERTICES)) ? NW'(vcount_q) : NW'(MAX_VERTICES);
  assign n32 = 32'(n_w);
  assign a32 = 32'(in_data_i.tail_or_index);
  assign b32 = 32'(in_data_i.head_or_vertex);
  assign out_free = !out_valid_q || !out_stall_i;
  assign tot_w = total_q + NW'(1);
  assign sz_w = total_q - before_q;
  assign adv_w = comp_q ? (i_q + NW'(1)) : (i_q - NW'(1));
  assign first_w = list_rdata[2*EW-1:EW];
  assign last_w = list_rdata[EW-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  always_comb begin
    state_d = state_q;
    vcount_d = cfg_we_i ? cfg_wdata_i : vcount_q;
    edge_used_d = edge_used_q;
    total_d = total_q;
    sizes_d = sizes_q;
    cnt_d = cnt_q;
    clr_list_d = clr_list_q;
    pend_d = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    op_d = op_q;
    a_d = a_q;
    e_d = e_q;
    res_value_d = res_value_q;
    res_err_d = res_err_q;
    comp_d = comp_q;
    i_d = i_q;
    root_d = root_q;
    before_d = before_q;
    top_v_d = top_v_q;
    top_c_d = top_c_q;
    depth_d = depth_q;
    h_d = h_q;
    out_data_d = out_data_q;

    heads_we = 1'b0; heads_waddr = '0; heads_wdata = '0; heads_raddr = '0;
    next_we = 1'b0; next_waddr = '0; next_wdata = '0; next_raddr = '0;
    list_we = 1'b0; list_waddr = '0; list_wdata = '0; list_raddr = '0;
    expl_we = 1'b0; expl_waddr = '0; expl_wdata = 1'b0; expl_raddr = '0;
    fin_we = 1'b0; fin_waddr = '0; fin_wdata = '0; fin_raddr = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
    size_we = 1'b0; size_waddr = '0; size_wdata = '0; size_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.op;
          a_d = VW'(a32);
          res_value_d = '0;
          res_err_d = 1'b0;
          state_d = S_FIN;
          case (in_data_i.op)
            OP_CLEAR_ALL, OP_CLEAR_SEARCH: begin
              // The graph clear also empties every edge list during the sweep.
              clr_list_d = (in_data_i.op == OP_CLEAR_ALL);
              if (in_data_i.op == OP_CLEAR_ALL) begin
                edge_used_d = '0;
              end
              total_d = '0;
              sizes_d = '0;
              cnt_d = '0;
              pend_d = 1'b1;
              state_d = S_SWEEP;
            end
            OP_ADD_EDGE: begin
              if (a32 >= n32 || b32 >= n32 || 32'(edge_used_q) >= 32'(MAX_EDGES)) begin
                res_err_d = 1'b1;
              end else begin
                // The new edge is written as the list tail right away.
                heads_we = 1'b1;
                heads_waddr = EAW'(edge_used_q);
                heads_wdata = VW'(b32);
                next_we = 1'b1;
                next_waddr = EAW'(edge_used_q);
                next_wdata = NIL;
                list_raddr = VW'(a32);
                e_d = EAW'(edge_used_q);
                edge_used_d = edge_used_q + EW'(1);
                state_d = S_LINK;
              end
            end
            OP_FINISH_PASS: begin
              comp_d = 1'b0;
              i_d = n_w;
              state_d = S_RNEXT;
            end
            OP_WRITE_ORDER: begin
              if (a32 >= n32 || b32 >= n32) begin
                res_err_d = 1'b1;
              end else begin
                ord_we = 1'b1;
                ord_waddr = VW'(a32);
                ord_wdata = VW'(b32);
              end
            end
            OP_COMP_PASS: begin
              comp_d = 1'b1;
              i_d = '0;
              state_d = S_RNEXT;
            end
            OP_READ_FINISH: begin
              if (a32 >= n32) begin
                res_err_d = 1'b1;
              end else begin
                fin_raddr = VW'(a32);
                state_d = S_READ;
              end
            end
            OP_READ_SIZE: begin
              if (a32 >= 32'(sizes_q)) begin
                res_err_d = 1'b1;
              end else begin
                size_raddr = SAW'(a32);
                state_d = S_READ;
              end
            end
            default: begin
              res_err_d = 1'b0;
            end
          endcase
        end
      end
      S_SWEEP: begin
        expl_we = 1'b1;
        expl_waddr = cnt_q;
        fin_we = 1'b1;
        fin_waddr = cnt_q;
        if (clr_list_q) begin
          list_we = 1'b1;
          list_waddr = cnt_q;
          list_wdata = {NIL, EW'(0)};
        end
        cnt_d = cnt_q + VW'(1);
        if (cnt_q == LAST_VTX) begin
          state_d = pend_q ? S_FIN : S_IDLE;
        end
      end
      S_LINK: begin
        list_we = 1'b1;
        list_waddr = a_q;
        if (first_w == NIL) begin
          list_wdata = {EW'(e_q), EW'(e_q)};
        end else begin
          list_wdata = {first_w, EW'(e_q)};
          next_we = 1'b1;
          next_waddr = EAW'(last_w);
          next_wdata = EW'(e_q);
        end
        state_d = S_FIN;
      end
      S_READ: begin
        if (op_q == OP_READ_FINISH) begin
          res_value_d = ValueW'(fin_rdata);
        end else begin
          res_value_d = ValueW'(size_rdata);
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d.value = res_value_q;
          out_data_d.component_count = CountW'(sizes_q);
          out_data_d.error = res_err_q;
          pend_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_RNEXT: begin
        // Root scan: finish pass counts down from n, component pass walks the order.
        if (!comp_q) begin
          if (i_q == '0) begin
            state_d = S_FIN;
          end else begin
            root_d = VW'(i_q - NW'(1));
            expl_raddr = VW'(i_q - NW'(1));
            state_d = S_RCHK;
          end
        end else begin
          if (i_q == n_w) begin
            state_d = S_FIN;
          end else begin
            ord_raddr = VW'(i_q);
            state_d = S_RORD;
          end
        end
      end
      S_RORD: begin
        if (32'(ord_rdata) < n32) begin
          root_d = ord_rdata;
          expl_raddr = ord_rdata;
          state_d = S_RCHK;
        end else begin
          i_d = adv_w;
          state_d = S_RNEXT;
        end
      end
      S_RCHK: begin
        if (expl_rdata) begin
          i_d = adv_w;
          state_d = S_RNEXT;
        end else begin
          expl_we = 1'b1;
          expl_waddr = root_q;
          expl_wdata = 1'b1;
          list_raddr = root_q;
          before_d = total_q;
          state_d = S_RSTART;
        end
      end
      S_RSTART: begin
        top_v_d = root_q;
        top_c_d = first_w;
        depth_d = NW'(1);
        state_d = S_STEP;
      end
      S_STEP: begin
        // The stack top lives in registers; lower entries are in the stack memory.
        if (top_c_q != NIL) begin
          heads_raddr = EAW'(top_c_q);
          next_raddr = EAW'(top_c_q);
          state_d = S_EDGE;
        end else begin
          total_d = tot_w;
          if (tot_w <= n_w) begin
            fin_we = 1'b1;
            fin_waddr = VW'(n_w - tot_w);
            fin_wdata = top_v_q;
          end
          depth_d = depth_q - NW'(1);
          if (depth_q != NW'(1)) begin
            stk_raddr = VW'(depth_q - NW'(2));
            state_d = S_POP;
          end else begin
            state_d = S_RDONE;
          end
        end
      end
      S_EDGE: begin
        top_c_d = next_rdata;
        h_d = heads_rdata;
        if (32'(heads_rdata) < n32) begin
          expl_raddr = heads_rdata;
          state_d = S_MARK;
        end else begin
          state_d = S_STEP;
        end
      end
      S_MARK: begin
        if (!expl_rdata && 32'(depth_q) < 32'(MAX_VERTICES)) begin
          expl_we = 1'b1;
          expl_waddr = h_q;
          expl_wdata = 1'b1;
          stk_we = 1'b1;
          stk_waddr = VW'(depth_q - NW'(1));
          stk_wdata = {top_v_q, top_c_q};
          list_raddr = h_q;
          state_d = S_PUSH;
        end else begin
          state_d = S_STEP;
        end
      end
      S_PUSH: begin
        top_v_d = h_q;
        top_c_d = first_w;
        depth_d = depth_q + NW'(1);
        state_d = S_STEP;
      end
      S_POP: begin
        top_v_d = stk_rdata[VW+EW-1:EW];
        top_c_d = stk_rdata[EW-1:0];
        state_d = S_STEP;
      end
      S_RDONE: begin
        // In the component pass, a tree of more than one vertex is recorded as a component while size slots remain.
        if (comp_q && sz_w > NW'(1) && 32'(sizes_q) < 32'(SLOTS)) begin
          size_we = 1'b1;
          size_waddr = SAW'(sizes_q);
          size_wdata = sz_w;
          sizes_d = sizes_q + SW'(1);
        end
        i_d = adv_w;
        state_d = S_RNEXT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      vcount_q <= VcReset;
      edge_used_q <= '0;
      total_q <= '0;
      sizes_q <= '0;
      cnt_q <= '0;
      clr_list_q <= 1'b1;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vcount_q <= vcount_d;
      edge_used_q <= edge_used_d;
      total_q <= total_d;
      sizes_q <= sizes_d;
      cnt_q <= cnt_d;
      clr_list_q <= clr_list_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    a_q <= a_d;
    e_q <= e_d;
    res_value_q <= res_value_d;
    res_err_q <= res_err_d;
    comp_q <= comp_d;
    i_q <= i_d;
    root_q <= root_d;
    before_q <= before_d;
    top_v_q <= top_v_d;
    top_c_q <= top_c_d;
    depth_q <= depth_d;
    h_q <= h_d;
    out_data_q <= out_data_d;
  end

  dfsfc_ram #(.Width(VW), .Depth(MAX_EDGES)) u_heads (
    .clk_i, .we_i(heads_we), .waddr_i(heads_waddr), .wdata_i(heads_wdata),
    .raddr_i(heads_raddr), .rdata_o(heads_rdata)
  );

  dfsfc_ram #(.Width(EW), .Depth(MAX_EDGES)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(next_raddr), .rdata_o(next_rdata)
  );

  dfsfc_ram #(.Width(2 * EW), .Depth(MAX_VERTICES)) u_list (
    .clk_i, .we_i(list_we), .waddr_i(list_waddr), .wdata_i(list_wdata),
    .raddr_i(list_raddr), .rdata_o(list_rdata)
  );

  dfsfc_ram #(.Width(1), .Depth(MAX_VERTICES)) u_expl (
    .clk_i, .we_i(expl_we), .waddr_i(expl_waddr), .wdata_i(expl_wdata),
    .raddr_i(expl_raddr), .rdata_o(expl_rdata)
  );

  dfsfc_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_fin (
    .clk_i, .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(fin_wdata),
    .raddr_i(fin_raddr), .rdata_o(fin_rdata)
  );

  dfsfc_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  dfsfc_ram #(.Width(VW + EW), .Depth(MAX_VERTICES)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  dfsfc_ram #(.Width(NW), .Depth(SLOTS)) u_size (
    .clk_i, .we_i(size_we), .waddr_i(size_waddr), .wdata_i(size_wdata),
    .raddr_i(size_raddr), .rdata_o(size_rdata)
  );

  // Every accepted transfer starts some work before the core is idle again.
  `DFSFC_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE, "idle after accept")
  `DFSFC_ASSERT_IMP(a_edge_bound, 1'b1, 32'(edge_used_q) <= 32'(MAX_EDGES), "edge count overflow")
  `DFSFC_ASSERT_IMP(a_total_bound, 1'b1, 32'(total_q) <= 32'(MAX_VERTICES), "finish count overflow")
  `DFSFC_ASSERT_IMP(a_size_bound, 1'b1, 32'(sizes_q) <= 32'(SLOTS), "size count overflow")

endmodule
